// ===== rtl/olar_pkg.sv =====
// ----------------------------------------------------------------------------
// olar_pkg
// Shared types and codes for the ordered list block: request and result
// payloads, command kinds and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package olar_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CNT_W        = 7;
    localparam int DATA_W       = 32;

    // command kinds
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_ELEMENT   = 3'd5;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] element;
        logic [CNT_W-1:0]         occupancy;
        logic                     last;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/ordered_list_append_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// Ordered list of signed 32-bit values in a single-port-write, registered-read
// store, walked one entry at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with kind and value; results
//   leave on o_out_valid / i_out_ready through one output register. A request
//   is taken only while the sequencer is idle; one request is worked on at a
//   time, and a finished result may still wait in the output register while
//   the next request is taken.
//   Append: one result, through S_RESP and the output register.
//   Remove: the search reads and compares one entry at a time, then the
//   shift that closes the gap moves one entry at a time, each entry read
//   through the single store read port.
//   Dump: one result per stored entry, each read and then loaded, the final
//   one marked last; an empty list gives one empty result.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset clears the occupancy count, the sequencer and the output valid;
//   store contents are not cleared and only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_append_remove #(
    parameter int CAPACITY = olar_pkg::CAPACITY_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  olar_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output olar_pkg::t_out   o_out_data
);
    import olar_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SRCH_RD  = 8'b0000_0010,
        S_SRCH_CMP = 8'b0000_0100,
        S_SHF_RD   = 8'b0000_1000,
        S_SHF_WR   = 8'b0001_0000,
        S_DUMP_RD  = 8'b0010_0000,
        S_DUMP_LD  = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } t_state;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [DATA_W-1:0] r_value, n_value;
    logic [2:0]        r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              out_free;
    logic              in_take;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  idx_p2;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_take = i_in_valid && o_in_ready;
    assign idx_p1 = r_idx + CNT_W'(1);
    assign idx_p2 = r_idx + CNT_W'(2);

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_value     = r_value;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_waddr   = r_count[AW-1:0];
        mem_wdata   = r_value;
        mem_re      = 1'b0;
        mem_raddr   = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_value = i_in_data.value;
                    n_idx   = '0;
                    case (i_in_data.kind)
                        KIND_APPEND: begin
                            if (r_count < CAP_CNT) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = i_in_data.value;
                                n_count   = r_count + CNT_W'(1);
                                n_status  = ST_ADDED;
                            end else begin
                                n_status  = ST_FULL;
                            end
                            n_state = S_RESP;
                        end
                        KIND_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_SRCH_RD;
                            end
                        end
                        KIND_DUMP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state  = S_DUMP_RD;
                            end
                        end
                        default: begin
                            // drop unused kind
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (r_rdata == r_value) begin
                    if (idx_p1 < r_count) begin
                        n_state = S_SHF_RD;
                    end else begin
                        n_count  = r_count - CNT_W'(1);
                        n_status = ST_REMOVED;
                        n_state  = S_RESP;
                    end
                end else if (idx_p1 < r_count) begin
                    n_idx   = idx_p1;
                    n_state = S_SRCH_RD;
                end else begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end
            end
            S_SHF_RD: begin
                mem_re    = 1'b1;
                mem_raddr = idx_p1[AW-1:0];
                n_state   = S_SHF_WR;
            end
            S_SHF_WR: begin
                // move the later entry down into the gap
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = r_rdata;
                n_idx     = idx_p1;
                if (idx_p2 < r_count) begin
                    n_state = S_SHF_RD;
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    n_status = ST_REMOVED;
                    n_state  = S_RESP;
                end
            end
            S_DUMP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx[AW-1:0];
                n_state   = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = ST_ELEMENT;
                    n_out.element   = r_rdata;
                    n_out.occupancy = r_count;
                    n_out.last      = (idx_p1 == r_count);
                    if (idx_p1 == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = idx_p1;
                        n_state = S_DUMP_RD;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.status    = r_status;
                    n_out.element   = '0;
                    n_out.occupancy = r_count;
                    n_out.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_status <= n_status;
        r_out    <= n_out;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("occupancy above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
            || r_count == $past(r_count) + CNT_W'(1)
            || r_count == $past(r_count) - CNT_W'(1)))
        else $error("occupancy moved by more than one");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in_data.kind == KIND_APPEND && r_count < CAP_CNT)
            |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not grow the list");

    a_elem_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_ELEMENT)
            |-> (o_out_data.occupancy != '0))
        else $error("element result from an empty list");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CNT_W'(mem_waddr) < CAP_CNT))
        else $error("store write beyond capacity");
`endif

endmodule

`default_nettype wire
